@@ rtl/clpr_pkg.sv @@
`default_nettype none
package clpr_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int TOL_W      = 31;
  localparam int IDX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OP_W       = 68;
  localparam int PROD_W     = 2 * OP_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int DD_W       = 66;
  localparam int T2_W       = 62;
  localparam int RHS_W      = 128;
  localparam int DIST_W     = 64;
  localparam int DIV_CNT_W  = 6;
  localparam int STEP_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 3'd6;

  localparam logic [COORD_W-1:0] RST_END_Z = 32'd65536;
  localparam logic [TOL_W-1:0]   RST_TOL   = 31'd655;

  // steps of the per-item product sequence
  localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
  localparam logic [STEP_W-1:0] STEP_VD    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_TOL   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_SEG   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_CROSS = 5'd9;
  localparam logic [STEP_W-1:0] STEP_LAST  = 5'd17;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_D2, OP_V0, OP_V1, OP_V2, OP_WV,
    OP_TOL, OP_T2, OP_DD, OP_CX, OP_CY, OP_CZ
  } opsel_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_DD, DST_VD, DST_T2, DST_RHS, DST_CX, DST_CY, DST_CZ
  } dest_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_MUL, ST_ACC, ST_NEXT, ST_DIV, ST_UPD, ST_FIN
  } state_t;

  typedef struct packed {
    opsel_t sel_a;
    opsel_t sel_b;
    logic   neg;
    logic   clr;
    dest_t  dst;
  } step_t;

  typedef struct packed {
    logic  capture;
    logic  mul_start;
    logic  acc_en;
    logic  div_start;
    logic  upd;
    logic  report;
    step_t op;
  } cmd_t;

  typedef struct packed {
    logic layer;
    logic last;
    logic mul_last;
    logic div_last;
    logic dd_zero;
    logic outside;
    logic seg_fail;
    logic out_free;
  } stat_t;

  function automatic step_t mk_step(input opsel_t a, input opsel_t b, input logic neg,
                                    input logic clr, input dest_t dst);
    step_t s;
    s.sel_a = a;
    s.sel_b = b;
    s.neg   = neg;
    s.clr   = clr;
    s.dst   = dst;
    return s;
  endfunction

  function automatic step_t step_op(input logic [STEP_W-1:0] step);
    step_t s;
    case (step)
      5'd0:    s = mk_step(OP_D0,  OP_D0,  1'b0, 1'b1, DST_NONE);
      5'd1:    s = mk_step(OP_D1,  OP_D1,  1'b0, 1'b0, DST_NONE);
      5'd2:    s = mk_step(OP_D2,  OP_D2,  1'b0, 1'b0, DST_DD);
      5'd3:    s = mk_step(OP_V0,  OP_D0,  1'b0, 1'b1, DST_NONE);
      5'd4:    s = mk_step(OP_V1,  OP_D1,  1'b0, 1'b0, DST_NONE);
      5'd5:    s = mk_step(OP_V2,  OP_D2,  1'b0, 1'b0, DST_VD);
      5'd6:    s = mk_step(OP_TOL, OP_TOL, 1'b0, 1'b1, DST_T2);
      5'd7:    s = mk_step(OP_T2,  OP_DD,  1'b0, 1'b1, DST_RHS);
      5'd8:    s = mk_step(OP_WV,  OP_WV,  1'b0, 1'b1, DST_NONE);
      5'd9:    s = mk_step(OP_D1,  OP_V2,  1'b0, 1'b1, DST_NONE);
      5'd10:   s = mk_step(OP_D2,  OP_V1,  1'b1, 1'b0, DST_CX);
      5'd11:   s = mk_step(OP_D2,  OP_V0,  1'b0, 1'b1, DST_NONE);
      5'd12:   s = mk_step(OP_D0,  OP_V2,  1'b1, 1'b0, DST_CY);
      5'd13:   s = mk_step(OP_D0,  OP_V1,  1'b0, 1'b1, DST_NONE);
      5'd14:   s = mk_step(OP_D1,  OP_V0,  1'b1, 1'b0, DST_CZ);
      5'd15:   s = mk_step(OP_CX,  OP_CX,  1'b0, 1'b1, DST_NONE);
      5'd16:   s = mk_step(OP_CY,  OP_CY,  1'b0, 1'b0, DST_NONE);
      5'd17:   s = mk_step(OP_CZ,  OP_CZ,  1'b0, 1'b0, DST_NONE);
      default: s = mk_step(OP_D0,  OP_D0,  1'b0, 1'b1, DST_NONE);
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/clpr_in_if.sv @@
`default_nettype none
interface clpr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [clpr_pkg::COORD_W-1:0] point_x;
  logic signed [clpr_pkg::COORD_W-1:0] point_y;
  logic signed [clpr_pkg::COORD_W-1:0] point_z;
  logic        [clpr_pkg::IDX_W-1:0]   cand_index;
  logic                                in_layer;
  logic                                last_candidate;

  modport source (output valid, point_x, point_y, point_z, cand_index, in_layer,
                  last_candidate, input ready);
  modport sink (input valid, point_x, point_y, point_z, cand_index, in_layer,
                last_candidate, output ready);
endinterface
`default_nettype wire

@@ rtl/clpr_out_if.sv @@
`default_nettype none
interface clpr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [clpr_pkg::IDX_W-1:0]        best_point_index;

  modport source (output valid, found, best_point_index, input ready);
  modport sink (input valid, found, best_point_index, output ready);
endinterface
`default_nettype wire

@@ rtl/closest_point_to_ray_select_core.sv @@
// skipped item (outside the layer): passes through the start and finish states back to idle
// evaluated item: up to 18 products on the one shared bit-serial multiplier, each
//   accumulated, then the 64-step restoring divider, cut short when the distance
//   saturates; a degenerate ray ends after its dot products, without division
// items are taken only while idle; a last item waits while the output register is full
// reset: synchronous active low, clears control, search state and configuration registers to defaults
`default_nettype none
module closest_point_to_ray_select_core #(
  parameter int INDEX_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  clpr_in_if.sink                         in_chan,
  clpr_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [clpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpr_pkg::CFG_DATA_W-1:0] cfg_data
);

  clpr_pkg::cmd_t  cmd;
  clpr_pkg::stat_t st;
  logic            in_ready;

  clpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  clpr_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt_x      (in_chan.point_x),
    .pt_y      (in_chan.point_y),
    .pt_z      (in_chan.point_z),
    .pt_index  (in_chan.cand_index),
    .pt_layer  (in_chan.in_layer),
    .pt_last   (in_chan.last_candidate),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_found (out_chan.found),
    .out_index (out_chan.best_point_index)
  );

  assign in_chan.ready = in_ready;

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("ready held high after a request was taken");

  a_report_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> st.out_free)
    else $error("result reported into an occupied output register");

  a_report_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> out_chan.valid)
    else $error("reported result not presented");

  a_mul_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st.mul_last |-> !in_chan.ready)
    else $error("multiplier running while idle");
`endif

endmodule
`default_nettype wire

@@ rtl/clpr_mul.sv @@
`default_nettype none
module clpr_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [clpr_pkg::OP_W-1:0]   a_mag,
  input  logic [clpr_pkg::OP_W-1:0]   b_mag,
  output logic                        last,
  output logic [clpr_pkg::PROD_W-1:0] prod
);

  logic                        run_r;
  logic [clpr_pkg::PROD_W-1:0] mc_r;
  logic [clpr_pkg::PROD_W-1:0] prod_r;
  logic [clpr_pkg::OP_W-1:0]   mp_r;

  // shift-add, one multiplier bit a cycle, stops after the top set bit
  assign last = run_r && (mp_r[clpr_pkg::OP_W-1:1] == '0);
  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (last) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r   <= clpr_pkg::PROD_W'(a_mag);
      mp_r   <= b_mag;
      prod_r <= '0;
    end else if (run_r) begin
      if (mp_r[0]) begin
        prod_r <= prod_r + mc_r;
      end
      mc_r <= {mc_r[clpr_pkg::PROD_W-2:0], 1'b0};
      mp_r <= {1'b0, mp_r[clpr_pkg::OP_W-1:1]};
    end
  end

endmodule
`default_nettype wire

@@ rtl/clpr_div.sv @@
`default_nettype none
module clpr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [clpr_pkg::PROD_W-1:0] num,
  input  logic [clpr_pkg::DD_W-1:0]   den,
  output logic                        last,
  output logic [clpr_pkg::DIST_W-1:0] quo
);

  localparam int HI_W = clpr_pkg::PROD_W - clpr_pkg::DIST_W;

  logic                           run_r;
  logic                           sat_r;
  logic [clpr_pkg::DD_W-1:0]      rem_r;
  logic [clpr_pkg::DIST_W-1:0]    quo_r;
  logic [clpr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [HI_W-1:0]                hi;
  logic [clpr_pkg::DD_W:0]        rem_sh;
  logic                           ge;

  assign hi     = num[clpr_pkg::PROD_W-1:clpr_pkg::DIST_W];
  assign rem_sh = {rem_r, quo_r[clpr_pkg::DIST_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign last   = run_r && (sat_r ||
                  cnt_r == clpr_pkg::DIV_CNT_W'(clpr_pkg::DIST_W - 1));
  assign quo    = sat_r ? '1 : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (last) begin
      run_r <= 1'b0;
    end
  end

  // restoring division, one quotient bit a cycle; quotient needs more
  // than 64 bits exactly when the upper part is not below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      sat_r <= hi >= HI_W'(den);
      rem_r <= hi[clpr_pkg::DD_W-1:0];
      quo_r <= num[clpr_pkg::DIST_W-1:0];
      cnt_r <= '0;
    end else if (run_r && !sat_r) begin
      rem_r <= ge ? clpr_pkg::DD_W'(rem_sh - {1'b0, den}) : rem_sh[clpr_pkg::DD_W-1:0];
      quo_r <= {quo_r[clpr_pkg::DIST_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/clpr_ctrl.sv @@
`default_nettype none
module clpr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  clpr_pkg::stat_t st,
  output clpr_pkg::cmd_t  cmd
);

  clpr_pkg::state_t              state_r, state_nxt;
  logic [clpr_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clpr_pkg::ST_IDLE;
      step_r  <= clpr_pkg::STEP_FIRST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      clpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = clpr_pkg::ST_START;
        end
      end
      clpr_pkg::ST_START: begin
        if (!st.layer) begin
          state_nxt = clpr_pkg::ST_FIN;
        end else begin
          step_nxt      = clpr_pkg::STEP_FIRST;
          cmd.mul_start = 1'b1;
          state_nxt     = clpr_pkg::ST_MUL;
        end
      end
      clpr_pkg::ST_MUL: begin
        if (st.mul_last) begin
          state_nxt = clpr_pkg::ST_ACC;
        end
      end
      clpr_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = clpr_pkg::ST_NEXT;
      end
      clpr_pkg::ST_NEXT: begin
        if (step_r == clpr_pkg::STEP_VD) begin
          // degenerate ray skips; inside the segment skips the range test
          if (st.dd_zero) begin
            state_nxt = clpr_pkg::ST_FIN;
          end else begin
            step_nxt      = st.outside ? clpr_pkg::STEP_TOL : clpr_pkg::STEP_CROSS;
            cmd.mul_start = 1'b1;
            state_nxt     = clpr_pkg::ST_MUL;
          end
        end else if (step_r == clpr_pkg::STEP_SEG) begin
          if (st.seg_fail) begin
            state_nxt = clpr_pkg::ST_FIN;
          end else begin
            step_nxt      = clpr_pkg::STEP_CROSS;
            cmd.mul_start = 1'b1;
            state_nxt     = clpr_pkg::ST_MUL;
          end
        end else if (step_r == clpr_pkg::STEP_LAST) begin
          cmd.div_start = 1'b1;
          state_nxt     = clpr_pkg::ST_DIV;
        end else begin
          step_nxt      = step_r + clpr_pkg::STEP_W'(1);
          cmd.mul_start = 1'b1;
          state_nxt     = clpr_pkg::ST_MUL;
        end
      end
      clpr_pkg::ST_DIV: begin
        if (st.div_last) begin
          state_nxt = clpr_pkg::ST_UPD;
        end
      end
      clpr_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = clpr_pkg::ST_FIN;
      end
      clpr_pkg::ST_FIN: begin
        if (!st.last) begin
          state_nxt = clpr_pkg::ST_IDLE;
        end else if (st.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = clpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clpr_pkg::ST_IDLE;
      end
    endcase
    // operands follow the step being started, stores follow the running one
    cmd.op = clpr_pkg::step_op(cmd.mul_start ? step_nxt : step_r);
  end

endmodule
`default_nettype wire

@@ rtl/clpr_dp.sv @@
`default_nettype none
module clpr_dp #(
  parameter int INDEX_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [clpr_pkg::COORD_W-1:0]    pt_x,
  input  logic [clpr_pkg::COORD_W-1:0]    pt_y,
  input  logic [clpr_pkg::COORD_W-1:0]    pt_z,
  input  logic [clpr_pkg::IDX_W-1:0]      pt_index,
  input  logic                            pt_layer,
  input  logic                            pt_last,
  input  clpr_pkg::cmd_t                  cmd,
  output clpr_pkg::stat_t                 st,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [clpr_pkg::IDX_W-1:0]      out_index
);

  localparam int OP_W   = clpr_pkg::OP_W;
  localparam int ACC_W  = clpr_pkg::ACC_W;
  localparam int CW     = clpr_pkg::COORD_W;
  localparam int DW     = clpr_pkg::DIFF_W;
  localparam int KEEP_W = (INDEX_BITS < clpr_pkg::IDX_W) ? INDEX_BITS : clpr_pkg::IDX_W;

  logic [CW-1:0]                 start_r [3];
  logic [CW-1:0]                 end_r [3];
  logic [clpr_pkg::TOL_W-1:0]    tol_r;

  logic [CW-1:0]                 pt [3];
  logic [DW-1:0]                 d_r [3];
  logic [DW-1:0]                 v_r [3];
  logic [OP_W-1:0]               d_ext [3];
  logic [OP_W-1:0]               v_ext [3];
  logic [KEEP_W-1:0]             idx_r;
  logic                          layer_r;
  logic                          last_r;

  logic [ACC_W-1:0]              acc_r;
  logic [clpr_pkg::DD_W-1:0]     dd_r;
  logic [OP_W-1:0]               vd_r;
  logic [clpr_pkg::T2_W-1:0]     t2_r;
  logic [clpr_pkg::RHS_W-1:0]    rhs_r;
  logic [OP_W-1:0]               cx_r;
  logic [OP_W-1:0]               cy_r;
  logic [OP_W-1:0]               cz_r;
  logic                          psign_r;

  logic [OP_W-1:0]               dd_ext;
  logic [OP_W-1:0]               w_val;
  logic [OP_W-1:0]               op_a;
  logic [OP_W-1:0]               op_b;
  logic [OP_W-1:0]               a_mag;
  logic [OP_W-1:0]               b_mag;
  logic [clpr_pkg::PROD_W-1:0]   prod;
  logic [ACC_W-1:0]              pext;
  logic [ACC_W-1:0]              term;
  logic [ACC_W-1:0]              acc_nxt;
  logic                          mul_last;
  logic                          div_last;
  logic [clpr_pkg::DIST_W-1:0]   cand_dist;

  logic                          have_r;
  logic [clpr_pkg::DIST_W-1:0]   best_dist_r;
  logic [KEEP_W-1:0]             best_idx_r;
  logic                          out_valid_r;
  logic                          out_found_r;
  logic [clpr_pkg::IDX_W-1:0]    out_index_r;

  assign pt[0] = pt_x;
  assign pt[1] = pt_y;
  assign pt[2] = pt_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      start_r[1] <= '0;
      start_r[2] <= '0;
      end_r[0]   <= '0;
      end_r[1]   <= '0;
      end_r[2]   <= clpr_pkg::RST_END_Z;
      tol_r      <= clpr_pkg::RST_TOL;
    end else if (cfg_we) begin
      case (cfg_index)
        clpr_pkg::CFG_START_X: start_r[0] <= cfg_data;
        clpr_pkg::CFG_START_Y: start_r[1] <= cfg_data;
        clpr_pkg::CFG_START_Z: start_r[2] <= cfg_data;
        clpr_pkg::CFG_END_X:   end_r[0]   <= cfg_data;
        clpr_pkg::CFG_END_Y:   end_r[1]   <= cfg_data;
        clpr_pkg::CFG_END_Z:   end_r[2]   <= cfg_data;
        clpr_pkg::CFG_TOL:     tol_r      <= cfg_data[clpr_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // direction and offset from the start point, exact in 33 bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= {end_r[i][CW-1], end_r[i]} - {start_r[i][CW-1], start_r[i]};
        v_r[i] <= {pt[i][CW-1], pt[i]} - {start_r[i][CW-1], start_r[i]};
      end
      idx_r   <= pt_index[KEEP_W-1:0];
      layer_r <= pt_layer;
      last_r  <= pt_last;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_ext[i] = {{(OP_W-DW){d_r[i][DW-1]}}, d_r[i]};
      v_ext[i] = {{(OP_W-DW){v_r[i][DW-1]}}, v_r[i]};
    end
  end

  assign dd_ext = OP_W'(dd_r);
  // excess past the nearer end of the segment
  assign w_val  = vd_r[OP_W-1] ? vd_r : vd_r - dd_ext;

  always_comb begin
    case (cmd.op.sel_a)
      clpr_pkg::OP_D0:  op_a = d_ext[0];
      clpr_pkg::OP_D1:  op_a = d_ext[1];
      clpr_pkg::OP_D2:  op_a = d_ext[2];
      clpr_pkg::OP_V0:  op_a = v_ext[0];
      clpr_pkg::OP_V1:  op_a = v_ext[1];
      clpr_pkg::OP_V2:  op_a = v_ext[2];
      clpr_pkg::OP_WV:  op_a = w_val;
      clpr_pkg::OP_TOL: op_a = OP_W'(tol_r);
      clpr_pkg::OP_T2:  op_a = OP_W'(t2_r);
      clpr_pkg::OP_DD:  op_a = dd_ext;
      clpr_pkg::OP_CX:  op_a = cx_r;
      clpr_pkg::OP_CY:  op_a = cy_r;
      clpr_pkg::OP_CZ:  op_a = cz_r;
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.op.sel_b)
      clpr_pkg::OP_D0:  op_b = d_ext[0];
      clpr_pkg::OP_D1:  op_b = d_ext[1];
      clpr_pkg::OP_D2:  op_b = d_ext[2];
      clpr_pkg::OP_V0:  op_b = v_ext[0];
      clpr_pkg::OP_V1:  op_b = v_ext[1];
      clpr_pkg::OP_V2:  op_b = v_ext[2];
      clpr_pkg::OP_WV:  op_b = w_val;
      clpr_pkg::OP_TOL: op_b = OP_W'(tol_r);
      clpr_pkg::OP_T2:  op_b = OP_W'(t2_r);
      clpr_pkg::OP_DD:  op_b = dd_ext;
      clpr_pkg::OP_CX:  op_b = cx_r;
      clpr_pkg::OP_CY:  op_b = cy_r;
      clpr_pkg::OP_CZ:  op_b = cz_r;
      default:          op_b = '0;
    endcase
  end

  // sign and magnitude into the unsigned multiplier
  assign a_mag = op_a[OP_W-1] ? (~op_a + 1'b1) : op_a;
  assign b_mag = op_b[OP_W-1] ? (~op_b + 1'b1) : op_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      psign_r <= op_a[OP_W-1] ^ op_b[OP_W-1] ^ cmd.op.neg;
    end
  end

  clpr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .last  (mul_last),
    .prod  (prod)
  );

  assign pext    = {1'b0, prod};
  assign term    = psign_r ? (~pext + 1'b1) : pext;
  assign acc_nxt = (cmd.op.clr ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
      case (cmd.op.dst)
        clpr_pkg::DST_DD:  dd_r  <= acc_nxt[clpr_pkg::DD_W-1:0];
        clpr_pkg::DST_VD:  vd_r  <= acc_nxt[OP_W-1:0];
        clpr_pkg::DST_T2:  t2_r  <= acc_nxt[clpr_pkg::T2_W-1:0];
        clpr_pkg::DST_RHS: rhs_r <= acc_nxt[clpr_pkg::RHS_W-1:0];
        clpr_pkg::DST_CX:  cx_r  <= acc_nxt[OP_W-1:0];
        clpr_pkg::DST_CY:  cy_r  <= acc_nxt[OP_W-1:0];
        clpr_pkg::DST_CZ:  cz_r  <= acc_nxt[OP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_r[ACC_W-2:0]),
    .den   (dd_r),
    .last  (div_last),
    .quo   (cand_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (cmd.report) begin
      have_r      <= 1'b0;
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (cmd.upd && (!have_r || cand_dist < best_dist_r)) begin
      have_r      <= 1'b1;
      best_dist_r <= cand_dist;
      best_idx_r  <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_found_r <= have_r;
      out_index_r <= have_r ? clpr_pkg::IDX_W'(best_idx_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_index = out_index_r;

  always_comb begin
    st          = '0;
    st.layer    = layer_r;
    st.last     = last_r;
    st.mul_last = mul_last;
    st.div_last = div_last;
    st.dd_zero  = dd_r == '0;
    st.outside  = vd_r[OP_W-1] || (vd_r > dd_ext);
    // 4*w*w against tol*tol*dd, w*w sits in the accumulator
    st.seg_fail = {acc_r[ACC_W-2:0], 2'b00} > (ACC_W + 1)'(rhs_r);
    st.out_free = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire
